>>> sv/hgpc_pkg.sv
// Shared widths, limits and codes for the hypergeometric probability table unit.
// No dependencies; every other file refers to this package by scoped names.
package hgpc_pkg;

  // Field widths of the request and result beats.
  localparam int CountW = 6;
  localparam int FracBits = 32;
  localparam int ProbW = FracBits + 1;

  // Largest population count accepted before saturation.
  localparam logic [CountW-1:0] MaxPopCount = 6'd32;

  // Fixed-point 1.0.
  localparam logic [ProbW-1:0] ProbOne = {1'b1, {FracBits{1'b0}}};

  // Shared divider sizing.
  localparam int DivDdW = 96;
  localparam int DivDenW = 64;
  localparam int DivQW = 68;
  localparam int DivCntW = 7;

  // Which job the shared divider is doing.
  typedef enum logic [1:0] {
    DOP_BIN,
    DOP_FRAC,
    DOP_REC
  } div_op_t;

endpackage

>>> sv/hgpc_if.sv
// Valid/ready channels for request and result beats.
// Depends on hgpc_pkg for field widths.
interface hgpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [hgpc_pkg::CountW-1:0]    ones_count;
  logic [hgpc_pkg::CountW-1:0]    zeros_count;
  logic [hgpc_pkg::CountW-1:0]    draw_count;

  modport source (output valid, ones_count, zeros_count, draw_count, input ready);
  modport sink (input valid, ones_count, zeros_count, draw_count, output ready);
endinterface

interface hgpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [hgpc_pkg::CountW-1:0]    ones_drawn;
  logic [hgpc_pkg::ProbW-1:0]     point_prob;
  logic [hgpc_pkg::ProbW-1:0]     cumulative_prob;
  logic                           last_row;

  modport source (output valid, ones_drawn, point_prob, cumulative_prob, last_row,
                  input ready);
  modport sink (input valid, ones_drawn, point_prob, cumulative_prob, last_row,
                output ready);
endinterface

>>> sv/hypergeometric_pmf_cdf_table_unit.sv
// Top level of the hypergeometric probability table unit.
// Depends on hgpc_pkg and the channel interfaces in hgpc_if.sv.
//
// One request beat on in_ch (ones_count n1, zeros_count n2, draw_count n)
// produces n+1 result beats on out_ch, rows k = 0..n in order, each with
// the point probability and the running cumulative probability as
// unsigned fixed point with 32 fraction bits (1.0 = 2^32), truncated.
// last_row marks row n. Ones and zeros counts above 32 are saturated to 32.
// in_ch.ready is high only while the unit is idle; it drops for the whole
// table. All division goes through one restoring divider that retires one
// quotient bit per cycle. It builds the three binomials (at most 64 steps for
// all three), divides their product for the first support term and derives
// each later support row from the one before; rows outside the support skip
// the divider altogether.
// Each result sits in an output register until out_ch.ready takes it; the
// sequencer waits while the receiver stalls and loses nothing.
// Reset (rst_n low, synchronous) returns the unit to idle and drops
// out_ch.valid; a table in progress is abandoned.
module hypergeometric_pmf_cdf_table_unit (
  input  logic     clk,
  input  logic     rst_n,
  hgpc_in_if.sink  in_ch,
  hgpc_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_BINIT, S_BMUL, S_NMUL, S_DIV, S_ROW, S_RMUL, S_EMIT, S_WAIT
  } state_t;

  state_t state_r;

  logic [5:0]  n1_r, n2_r, n_r, k1_r, k2_r, i_r;
  logic        empty_r, use_p_r;
  logic [1:0]  bsel_r;
  logic [6:0]  a_r;
  logic [5:0]  bb_r, j_r;
  logic [60:0] acc_r;
  logic [29:0] bin0_r, bin1_r;
  logic [60:0] bin2_r;
  logic [12:0] fm_r;
  logic [11:0] fd_r;
  logic [hgpc_pkg::ProbW-1:0] p_r, cum_r;

  logic [hgpc_pkg::DivDdW-1:0]  dd_r;
  logic [hgpc_pkg::DivDenW-1:0] den_r;
  logic [hgpc_pkg::DivDenW-1:0] rem_r;
  logic [hgpc_pkg::DivQW-1:0]   q_r;
  logic [hgpc_pkg::DivCntW-1:0] cnt_r;
  hgpc_pkg::div_op_t            op_r;

  logic                       out_valid_r, last_r;
  logic [5:0]                 row_r;
  logic [hgpc_pkg::ProbW-1:0] pt_out_r, cum_out_r;

  // Saturated request fields and support bounds.
  logic [5:0] n1_in, n2_in, n_in, k1_in, k2_in;
  always_comb begin
    n1_in = (in_ch.ones_count > hgpc_pkg::MaxPopCount) ? hgpc_pkg::MaxPopCount
                                                       : in_ch.ones_count;
    n2_in = (in_ch.zeros_count > hgpc_pkg::MaxPopCount) ? hgpc_pkg::MaxPopCount
                                                        : in_ch.zeros_count;
    n_in  = in_ch.draw_count;
    k1_in = (n_in <= n2_in) ? 6'd0 : 6'(n_in - n2_in);
    k2_in = (n_in <= n1_in) ? n_in : n1_in;
  end

  // Binomial operands for the one being built.
  logic [6:0] bin_a, bin_b, bin_ab;
  always_comb begin
    case (bsel_r)
      2'd0: begin
        bin_a = {1'b0, n1_r};
        bin_b = {1'b0, k1_r};
      end
      2'd1: begin
        bin_a = {1'b0, n2_r};
        bin_b = 7'(n_r - k1_r);
      end
      default: begin
        bin_a = {1'b0, n1_r} + {1'b0, n2_r};
        bin_b = {1'b0, n_r};
      end
    endcase
    bin_ab = bin_a - bin_b;
  end

  // Multiplier operands and products feeding the divider.
  logic [67:0] bin_prod;
  logic [59:0] num_prod;
  logic [45:0] rec_prod;
  logic [5:0]  t1, t3;
  logic [6:0]  t2;
  logic        in_sup;
  always_comb begin
    bin_prod = acc_r * 68'(a_r - {1'b0, j_r});
    num_prod = bin0_r * 60'(bin1_r);
    rec_prod = p_r * 46'(fm_r);
    t1 = 6'(n1_r - i_r + 6'd1);
    t2 = {1'b0, n_r} - {1'b0, i_r} + 7'd1;
    t3 = 6'(n2_r + i_r - n_r);
    in_sup = !empty_r && (i_r >= k1_r) && (i_r <= k2_r);
  end

  // One restoring divider step: shift in a dividend bit, trial subtract.
  logic [hgpc_pkg::DivDenW:0]   rem_sh;
  logic                         ge;
  logic [hgpc_pkg::DivDenW-1:0] rem_nxt;
  logic [hgpc_pkg::DivQW-1:0]   q_sat_src;
  logic [hgpc_pkg::ProbW-1:0]   q_sat;
  always_comb begin
    rem_sh  = {rem_r, dd_r[hgpc_pkg::DivDdW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? hgpc_pkg::DivDenW'(rem_sh - {1'b0, den_r})
                 : hgpc_pkg::DivDenW'(rem_sh);
    q_sat_src = q_r;
    q_sat = (q_sat_src > hgpc_pkg::DivQW'(hgpc_pkg::ProbOne)) ? hgpc_pkg::ProbOne
                                                               : q_sat_src[32:0];
  end

  // Running sum for the row being emitted; S_EMIT holds it at 1.0.
  logic [hgpc_pkg::ProbW-1:0] pt;
  logic [hgpc_pkg::ProbW:0]   cum_sum;
  always_comb begin
    pt = use_p_r ? p_r : '0;
    cum_sum = {1'b0, cum_r} + {1'b0, pt};
  end

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            n1_r    <= n1_in;
            n2_r    <= n2_in;
            n_r     <= n_in;
            k1_r    <= k1_in;
            k2_r    <= k2_in;
            empty_r <= k1_in > k2_in;
            i_r     <= '0;
            cum_r   <= '0;
            p_r     <= '0;
            bsel_r  <= 2'd0;
            state_r <= (k1_in > k2_in) ? S_ROW : S_BINIT;
          end
        end
        S_BINIT: begin
          a_r     <= bin_a;
          bb_r    <= (bin_b <= bin_ab) ? bin_b[5:0] : bin_ab[5:0];
          acc_r   <= 61'd1;
          j_r     <= '0;
          state_r <= S_BMUL;
        end
        S_BMUL: begin
          if (j_r == bb_r) begin
            case (bsel_r)
              2'd0:    bin0_r <= acc_r[29:0];
              2'd1:    bin1_r <= acc_r[29:0];
              default: bin2_r <= acc_r;
            endcase
            if (bsel_r == 2'd2) begin
              state_r <= S_NMUL;
            end else begin
              bsel_r  <= bsel_r + 2'd1;
              state_r <= S_BINIT;
            end
          end else begin
            dd_r    <= {bin_prod, 28'd0};
            den_r   <= hgpc_pkg::DivDenW'(j_r) + 64'd1;
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= 7'd68;
            op_r    <= hgpc_pkg::DOP_BIN;
            state_r <= S_DIV;
          end
        end
        S_NMUL: begin
          dd_r    <= {4'd0, num_prod, 32'd0};
          den_r   <= {3'd0, bin2_r};
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= 7'd96;
          op_r    <= hgpc_pkg::DOP_FRAC;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r != '0) begin
            rem_r <= rem_nxt;
            q_r   <= {q_r[hgpc_pkg::DivQW-2:0], ge};
            dd_r  <= {dd_r[hgpc_pkg::DivDdW-2:0], 1'b0};
            cnt_r <= cnt_r - 7'd1;
          end else begin
            case (op_r)
              hgpc_pkg::DOP_BIN: begin
                acc_r   <= q_r[60:0];
                j_r     <= j_r + 6'd1;
                state_r <= S_BMUL;
              end
              hgpc_pkg::DOP_FRAC: begin
                p_r     <= q_sat;
                state_r <= S_ROW;
              end
              default: begin
                p_r     <= q_sat;
                use_p_r <= 1'b1;
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_ROW: begin
          if (in_sup && (i_r != k1_r)) begin
            fm_r    <= t1 * 13'(t2);
            fd_r    <= t3 * 12'(i_r);
            state_r <= S_RMUL;
          end else begin
            use_p_r <= in_sup;
            state_r <= S_EMIT;
          end
        end
        S_RMUL: begin
          dd_r    <= {rec_prod, 50'd0};
          den_r   <= hgpc_pkg::DivDenW'(fd_r);
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= 7'd46;
          op_r    <= hgpc_pkg::DOP_REC;
          state_r <= S_DIV;
        end
        S_EMIT: begin
          cum_r       <= (cum_sum > {1'b0, hgpc_pkg::ProbOne}) ? hgpc_pkg::ProbOne
                                                                : cum_sum[32:0];
          cum_out_r   <= (cum_sum > {1'b0, hgpc_pkg::ProbOne}) ? hgpc_pkg::ProbOne
                                                                : cum_sum[32:0];
          pt_out_r    <= pt;
          row_r       <= i_r;
          last_r      <= i_r == n_r;
          out_valid_r <= 1'b1;
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (i_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 6'd1;
              state_r <= S_ROW;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = state_r == S_IDLE;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.ones_drawn      = row_r;
  assign out_ch.point_prob      = pt_out_r;
  assign out_ch.cumulative_prob = cum_out_r;
  assign out_ch.last_row        = last_r;

  // A table in progress never takes a new request.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("request taken during a table");

  // The running sum never falls below the row's own probability nor exceeds 1.0.
  a_cum_ge_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.point_prob <= out_ch.cumulative_prob
                      && out_ch.cumulative_prob <= hgpc_pkg::ProbOne))
    else $error("cumulative probability out of range");

  // The shared divider never runs with a zero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0)) else $error("divide by zero");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the hypergeometric probability table unit.
// Depends on hgpc_pkg, the channel interfaces in hgpc_if.sv and the unit itself.
// Each request is predicted in fixed point and every row is checked in order.
module tb_top;

  typedef logic [hgpc_pkg::CountW-1:0] count_t;
  typedef logic [hgpc_pkg::ProbW-1:0]  prob_t;

  typedef struct packed {
    count_t ones_drawn;
    prob_t  point_prob;
    prob_t  cumulative_prob;
    logic   last_row;
  } table_row_t;

  localparam longint unsigned CycleLimit = 64'd30_000_000;
  localparam int              DrainCycles = 64;

  logic clk;
  logic rst_n;

  hgpc_in_if  in_if ();
  hgpc_out_if out_if ();

  hypergeometric_pmf_cdf_table_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  table_row_t       pending_rows[$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               requests_sent;
  int               rows_checked;
  int               mismatches;
  longint unsigned  cycle_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: ends the run if the unit hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d rows outstanding", cycle_count,
               pending_rows.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Binomial coefficient built from one row of Pascal's triangle.
  function automatic longint unsigned choose(input int a, input int b);
    longint unsigned pascal[0:64];
    int r;
    int j;
    if (a > 64 || b > a || b < 0) return 0;
    for (j = 0; j <= 64; j++) pascal[j] = 0;
    pascal[0] = 1;
    for (r = 1; r <= a; r++)
      for (j = r; j >= 1; j--) pascal[j] = pascal[j] + pascal[j-1];
    return pascal[b];
  endfunction

  // Truncated num/den with FracBits fraction bits, held at 1.0.
  function automatic longint unsigned fixed_ratio(input longint unsigned num,
                                                  input longint unsigned den);
    logic [127:0] quot;
    if (den == 0) return 0;
    quot = ({64'd0, num} << hgpc_pkg::FracBits) / {64'd0, den};
    if (quot > hgpc_pkg::ProbOne) return hgpc_pkg::ProbOne;
    return quot[63:0];
  endfunction

  // Works out every row of the table for one request and queues them.
  task automatic predict_table(input count_t raw_ones, input count_t raw_zeros,
                               input count_t raw_draw);
    int n1;
    int n2;
    int n;
    int k_lo;
    int k_hi;
    int k;
    longint unsigned prob;
    longint unsigned point;
    longint unsigned running;
    longint unsigned mul;
    longint unsigned dv;
    table_row_t row;
    n1 = (raw_ones > hgpc_pkg::MaxPopCount) ? int'(hgpc_pkg::MaxPopCount) : int'(raw_ones);
    n2 = (raw_zeros > hgpc_pkg::MaxPopCount) ? int'(hgpc_pkg::MaxPopCount)
                                             : int'(raw_zeros);
    n = int'(raw_draw);
    k_lo = (n <= n2) ? 0 : n - n2;
    k_hi = (n <= n1) ? n : n1;
    prob = 0;
    running = 0;
    for (k = 0; k <= n; k++) begin
      point = 0;
      if (k_lo <= k_hi && k >= k_lo && k <= k_hi) begin
        if (k == k_lo) begin
          prob = fixed_ratio(choose(n1, k_lo) * choose(n2, n - k_lo),
                             choose(n1 + n2, n));
        end else begin
          mul = longint'(n1 - k + 1) * longint'(n - k + 1);
          dv = longint'(k) * longint'(n2 + k - n);
          prob = (dv != 0) ? (prob * mul) / dv : 0;
          if (prob > hgpc_pkg::ProbOne) prob = hgpc_pkg::ProbOne;
        end
        point = prob;
      end
      running = running + point;
      if (running > hgpc_pkg::ProbOne) running = hgpc_pkg::ProbOne;
      row.ones_drawn = count_t'(k);
      row.point_prob = prob_t'(point);
      row.cumulative_prob = prob_t'(running);
      row.last_row = (k == n);
      pending_rows.push_back(row);
    end
  endtask

  // Sends one request beat, with random gaps before it.
  task automatic send_request(input count_t ones, input count_t zeros, input count_t draw);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ones_count <= ones;
    in_if.zeros_count <= zeros;
    in_if.draw_count <= draw;
    do @(posedge clk); while (!in_if.ready);
    predict_table(ones, zeros, draw);
    requests_sent++;
  endtask

  // Waits until every expected row has arrived, then lets the unit settle.
  task automatic drain_tables();
    in_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Receiver: ready stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each accepted result beat against the oldest expected row.
  always @(posedge clk) begin
    table_row_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_rows.size() == 0) begin
        $error("Result beat with no row expected (ones_drawn %0d)", out_if.ones_drawn);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_if.ones_drawn !== want.ones_drawn) begin
          $error("ones_drawn: expected %0d, got %0d", want.ones_drawn, out_if.ones_drawn);
          mismatches++;
        end
        if (out_if.point_prob !== want.point_prob) begin
          $error("point_prob: expected %h, got %h", want.point_prob, out_if.point_prob);
          mismatches++;
        end
        if (out_if.cumulative_prob !== want.cumulative_prob) begin
          $error("cumulative_prob: expected %h, got %h", want.cumulative_prob,
                 out_if.cumulative_prob);
          mismatches++;
        end
        if (out_if.last_row !== want.last_row) begin
          $error("last_row: expected %0b, got %0b", want.last_row, out_if.last_row);
          mismatches++;
        end
      end
    end
  end

  // Random request: mostly legal counts, some above the saturation limit.
  task automatic send_random_request();
    count_t ones;
    count_t zeros;
    count_t draw;
    ones = ($urandom_range(9) == 0) ? count_t'($urandom_range(63, 33))
                                    : count_t'($urandom_range(32));
    zeros = ($urandom_range(9) == 0) ? count_t'($urandom_range(63, 33))
                                     : count_t'($urandom_range(32));
    // Usually draw within the population so that the support is not empty.
    if ($urandom_range(4) != 0)
      draw = count_t'($urandom_range(((ones > 32) ? 32 : ones) + ((zeros > 32) ? 32 : zeros)
                                     > 63 ? 63 : ((ones > 32) ? 32 : ones)
                                     + ((zeros > 32) ? 32 : zeros)));
    else
      draw = count_t'($urandom_range(63));
    send_request(ones, zeros, draw);
  endtask

  // Extremes of every field and each special case.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(6'd0, 6'd0, 6'd0);    // empty population, nothing drawn
    send_request(6'd0, 6'd0, 6'd5);    // drawing from an empty population
    send_request(6'd32, 6'd32, 6'd0);
    send_request(6'd32, 6'd32, 6'd32); // widest binomials
    send_request(6'd32, 6'd32, 6'd63); // largest table
    send_request(6'd63, 6'd63, 6'd63); // both counts saturate
    send_request(6'd63, 6'd0, 6'd10);
    send_request(6'd0, 6'd63, 6'd10);
    send_request(6'd5, 6'd0, 6'd5);    // certain outcome: only ones
    send_request(6'd0, 6'd5, 6'd5);    // certain outcome: only zeros
    send_request(6'd3, 6'd4, 6'd20);   // more drawn than the population
    send_request(6'd1, 6'd1, 6'd1);
    send_request(6'd10, 6'd3, 6'd8);   // support starts above zero
    send_request(6'd3, 6'd10, 6'd8);   // support ends below the draw count
    send_request(6'd7, 6'd9, 6'd16);   // whole population drawn
    send_request(6'd21, 6'd42, 6'd42);
    send_request(6'd42, 6'd21, 6'd21);
    send_request(6'd1, 6'd32, 6'd1);
    send_request(6'd32, 6'd1, 6'd33);
    send_request(6'd16, 6'd16, 6'd15);
    drain_tables();
  endtask

  task automatic test_random_no_idling(input int count);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (count) send_random_request();
    drain_tables();
  endtask

  task automatic test_random_sender_gaps(input int count);
    send_idle_pct = 51;
    recv_stall_pct = 0;
    repeat (count) send_random_request();
    drain_tables();
  endtask

  task automatic test_random_receiver_stalls(input int count);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    repeat (count) send_random_request();
    drain_tables();
  endtask

  task automatic test_random_both_idling(input int count);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    repeat (count) send_random_request();
    drain_tables();
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.ones_count = '0;
    in_if.zeros_count = '0;
    in_if.draw_count = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    requests_sent = 0;
    rows_checked = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_no_idling(30);
    test_random_sender_gaps(30);
    test_random_receiver_stalls(30);
    test_random_both_idling(30);

    $display("Sent %0d requests and checked %0d table rows in %0d cycles,", requests_sent,
             rows_checked, cycle_count);
    $display("covering saturated counts, empty supports and four idling patterns.");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/hgpc_pkg.sv
sv/hgpc_if.sv
sv/hypergeometric_pmf_cdf_table_unit.sv
bench/tb_top.sv
